// ===== rtl/hsac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsac_pkg;

    // default sizing, overridden from the top level
    localparam int DEF_SETS        = 64;
    localparam int DEF_WAYS        = 4;
    localparam int DEF_MAX_STROKES = 4;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int HASH_W     = 32;
    localparam int LEN_W      = 4;
    localparam int ELEN_W     = 3;   // stored key length
    localparam int WORD_W     = 32;
    localparam int KEY_WORDS  = 4;
    localparam int PROV_W     = 8;
    localparam int DEF_W      = 32;
    localparam int STAT_W     = 3;

    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 48;

    // remainder bits resolved per cycle for a set count that is not a power of two
    localparam int MOD_BITS = 4;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP  = 2'd0,
        OP_INSERT  = 2'd1,
        OP_REFRESH = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_MISS     = 3'd0,
        ST_HIT_DEF  = 3'd1,
        ST_HIT_PROV = 3'd2,
        ST_BYPASS   = 3'd3,
        ST_DONE     = 3'd4
    } t_status;

    typedef struct packed {
        logic capture;    // latch the input beat
        logic mod_start;  // start the set remainder unit
        logic rd_direct;  // read the row named by the incoming hash
        logic rd_set;     // read the row named by the remainder unit
        logic commit;     // write back, update flags, load output register
    } t_dp_cmd;

    typedef struct packed {
        logic set_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/hsac_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsac_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/hsac_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsac_ctrl import hsac_pkg::*; #(
    parameter int SETS = DEF_SETS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    localparam bit SET_POW2 = ((SETS & (SETS - 1)) == 0);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_CMP
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    if (SET_POW2) begin
                        o_cmd.rd_direct = 1'b1;
                        n_state         = S_CMP;
                    end else begin
                        o_cmd.mod_start = 1'b1;
                        n_state         = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (i_stat.set_done) begin
                    o_cmd.rd_set = 1'b1;
                    n_state      = S_CMP;
                end
            end
            S_CMP: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hsac_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsac_dp import hsac_pkg::*; #(
    parameter int SETS        = DEF_SETS,
    parameter int WAYS        = DEF_WAYS,
    parameter int MAX_STROKES = DEF_MAX_STROKES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire t_dp_cmd                           i_cmd,
    output t_dp_stat                               o_stat,
    input  wire t_op                               i_op,
    input  wire logic [HASH_W-1:0]                 i_key_hash,
    input  wire logic [LEN_W-1:0]                  i_key_length,
    input  wire logic [KEY_WORDS-1:0][WORD_W-1:0]  i_key_words,
    input  wire logic [PROV_W-1:0]                 i_provider,
    input  wire logic [DEF_W-1:0]                  i_definition,
    input  wire logic                              i_definition_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output t_status                                o_status,
    output logic [PROV_W-1:0]                      o_provider,
    output logic [DEF_W-1:0]                       o_definition,
    output logic                                   o_fill
);

    localparam int  SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int  PTR_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit  SET_POW2 = ((SETS & (SETS - 1)) == 0);
    localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);

    // entry layout, lowest bit first
    localparam int E_HASH  = 0;
    localparam int E_LEN   = E_HASH + HASH_W;
    localparam int E_WORDS = E_LEN + ELEN_W;
    localparam int E_PROV  = E_WORDS + MAX_STROKES * WORD_W;
    localparam int E_DEF   = E_PROV + PROV_W;
    localparam int E_DEFV  = E_DEF + DEF_W;
    localparam int ENTRY_W = E_DEFV + 1;
    localparam int E_PTR   = WAYS * ENTRY_W;
    localparam int ROW_W   = E_PTR + PTR_W;

    localparam int MOD_CYC = HASH_W / MOD_BITS;
    localparam int CNT_W   = $clog2(MOD_CYC + 1);

    // captured beat
    t_op                      r_op;
    logic [HASH_W-1:0]        r_hash;
    logic [LEN_W-1:0]         r_len;
    logic [WORD_W-1:0]        r_words [MAX_STROKES];
    logic [PROV_W-1:0]        r_prov;
    logic [DEF_W-1:0]         r_def;
    logic                     r_defv;

    // set index and remainder unit
    logic [SET_W-1:0]         r_set, n_rem;
    logic [HASH_W-1:0]        r_mod_hash;
    logic [CNT_W-1:0]         r_mod_cnt;

    // per-set flags
    logic [WAYS-1:0]          r_valid [SETS];
    logic [SETS-1:0]          r_row_init;

    // output register
    logic                     r_out_valid;
    t_status                  r_status;
    logic [PROV_W-1:0]        r_oprov;
    logic [DEF_W-1:0]         r_odef;
    logic                     r_ofill;

    logic                     ram_re, ram_we;
    logic [SET_W-1:0]         ram_raddr;
    logic [ROW_W-1:0]         row_rd, row_wr;

    logic                     too_long, hit, write;
    logic [WAYS-1:0]          match;
    logic [PTR_W-1:0]         ptr, hit_way, wr_way, new_ptr;
    logic [ENTRY_W-1:0]       hit_ent, new_ent, wr_ent;
    t_status                  res_status;
    logic [PROV_W-1:0]        res_prov;
    logic [DEF_W-1:0]         res_def;
    logic                     res_fill;

    // ---- remainder: MOD_BITS restoring steps per cycle
    always_comb begin
        logic [SET_W-1:0] rem;
        logic [SET_W:0]   t;
        rem = r_set;
        for (int j = 0; j < MOD_BITS; j++) begin
            t = {rem, r_mod_hash[HASH_W-1-j]};
            if (t >= (SET_W+1)'(SETS)) begin
                t = t - (SET_W+1)'(SETS);
            end
            rem = t[SET_W-1:0];
        end
        n_rem = rem;
    end

    assign o_stat.set_done = (r_mod_cnt == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_hash <= i_key_hash;
            r_len  <= i_key_length;
            for (int i = 0; i < MAX_STROKES; i++) begin
                r_words[i] <= i_key_words[i];
            end
            r_prov <= i_provider;
            r_def  <= i_definition;
            r_defv <= i_definition_valid;
            r_set  <= SET_POW2 ? (i_key_hash[SET_W-1:0] & SET_MASK) : '0;
        end else if (r_mod_cnt != '0) begin
            r_set <= n_rem;
        end
        if (i_cmd.mod_start) begin
            r_mod_hash <= i_key_hash;
        end else if (r_mod_cnt != '0) begin
            r_mod_hash <= r_mod_hash << MOD_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_cnt <= '0;
        end else if (i_cmd.mod_start) begin
            r_mod_cnt <= CNT_W'(MOD_CYC);
        end else if (r_mod_cnt != '0) begin
            r_mod_cnt <= r_mod_cnt - CNT_W'(1);
        end
    end

    // ---- row store
    assign ram_re    = i_cmd.rd_direct || i_cmd.rd_set;
    assign ram_raddr = i_cmd.rd_direct ? (i_key_hash[SET_W-1:0] & SET_MASK) : r_set;
    assign ram_we    = i_cmd.commit && write;

    hsac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_set),
        .i_wdata (row_wr),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (row_rd)
    );

    // ---- compare
    assign too_long = (r_len > LEN_W'(MAX_STROKES));
    // pointer reads as zero until the row has been written once
    assign ptr      = r_row_init[r_set] ? row_rd[E_PTR +: PTR_W] : '0;

    always_comb begin
        logic [ENTRY_W-1:0] ent;
        logic               m;
        match   = '0;
        hit_way = '0;
        hit_ent = '0;
        for (int w = 0; w < WAYS; w++) begin
            ent = row_rd[w*ENTRY_W +: ENTRY_W];
            m   = r_valid[r_set][w]
                  && (ent[E_HASH +: HASH_W] == r_hash)
                  && ({1'b0, ent[E_LEN +: ELEN_W]} == r_len);
            for (int i = 0; i < MAX_STROKES; i++) begin
                if ((LEN_W'(i) < r_len) && (ent[E_WORDS + i*WORD_W +: WORD_W] != r_words[i])) begin
                    m = 1'b0;
                end
            end
            match[w] = m;
        end
        // lowest matching way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = PTR_W'(w);
                hit_ent = row_rd[w*ENTRY_W +: ENTRY_W];
            end
        end
    end

    assign hit = |match;

    always_comb begin
        new_ent = '0;
        new_ent[E_HASH +: HASH_W] = r_hash;
        new_ent[E_LEN +: ELEN_W]  = r_len[ELEN_W-1:0];
        for (int i = 0; i < MAX_STROKES; i++) begin
            new_ent[E_WORDS + i*WORD_W +: WORD_W] = (LEN_W'(i) < r_len) ? r_words[i] : '0;
        end
        new_ent[E_PROV +: PROV_W] = r_prov;
        new_ent[E_DEF +: DEF_W]   = r_defv ? r_def : '0;
        new_ent[E_DEFV]           = r_defv;
    end

    // ---- write-back and result
    always_comb begin
        write      = 1'b0;
        wr_way     = ptr;
        wr_ent     = new_ent;
        new_ptr    = ptr;
        res_status = ST_DONE;
        res_prov   = '0;
        res_def    = '0;
        res_fill   = 1'b0;
        case (r_op)
            OP_LOOKUP: begin
                if (too_long) begin
                    res_status = ST_BYPASS;
                end else if (!hit) begin
                    res_status = ST_MISS;
                    res_fill   = 1'b1;
                end else begin
                    res_prov = hit_ent[E_PROV +: PROV_W];
                    if (hit_ent[E_DEFV]) begin
                        res_status = ST_HIT_DEF;
                        res_def    = hit_ent[E_DEF +: DEF_W];
                    end else begin
                        res_status = ST_HIT_PROV;
                    end
                end
            end
            OP_INSERT: begin
                if (!too_long) begin
                    write   = 1'b1;
                    new_ptr = (ptr == PTR_W'(WAYS - 1)) ? '0 : ptr + PTR_W'(1);
                end
            end
            OP_REFRESH: begin
                if (too_long) begin
                    res_status = ST_BYPASS;
                end else if (!hit) begin
                    res_status = ST_MISS;
                end else if (r_defv) begin
                    write                = 1'b1;
                    wr_way               = hit_way;
                    wr_ent               = hit_ent;
                    wr_ent[E_DEF +: DEF_W] = r_def;
                    wr_ent[E_DEFV]       = 1'b1;
                end
            end
            OP_CLEAR: begin
                res_status = ST_DONE;
            end
            default: res_status = ST_DONE;
        endcase
    end

    always_comb begin
        row_wr = row_rd;
        for (int w = 0; w < WAYS; w++) begin
            if (PTR_W'(w) == wr_way) begin
                row_wr[w*ENTRY_W +: ENTRY_W] = wr_ent;
            end
        end
        row_wr[E_PTR +: PTR_W] = new_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                r_valid[s] <= '0;
            end
            r_row_init <= '0;
        end else if (i_cmd.commit) begin
            if (r_op == OP_CLEAR) begin
                for (int s = 0; s < SETS; s++) begin
                    r_valid[s] <= '0;
                end
            end else if (write) begin
                r_row_init[r_set] <= 1'b1;
                if (r_op == OP_INSERT) begin
                    r_valid[r_set][ptr] <= 1'b1;
                end
            end
        end
    end

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= res_status;
            r_oprov  <= res_prov;
            r_odef   <= res_def;
            r_ofill  <= res_fill;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_provider   = r_oprov;
    assign o_definition = r_odef;
    assign o_fill       = r_ofill;

endmodule

`default_nettype wire

// ===== rtl/hashed_set_assoc_lookup_cache.sv =====
// With SETS a power of two, the input beat is captured and its row read, then compared and
//   written back; otherwise the remainder unit first finds the set, taking 4 hash bits a cycle.
// One beat is taken at a time, paced by the read-compare-write of one row; a result held back
//   on the master side stalls the compare step, and the next input beat with it.
// Reset: i_rst_n synchronous, active low; at once clears control, entry valid bits and
//   row-written flags, so replace pointers read as zero. No clearing pass; row contents stay
//   undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module hashed_set_assoc_lookup_cache import hsac_pkg::*; #(
    parameter int SETS        = DEF_SETS,
    parameter int WAYS        = DEF_WAYS,
    parameter int MAX_STROKES = DEF_MAX_STROKES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // key_hash[31:0], key_length[35:32], key_word_0[67:36], key_word_1[99:68],
    // key_word_2[131:100], key_word_3[163:132], provider_in[171:164],
    // definition_in[203:172], definition_in_valid[204], zero pad [207:205]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [OP_W-1:0]        s_axis_tuser,    // op[1:0]

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // provider_out[7:0], definition_out[39:8], fill_requested[40], zero pad [47:41]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [STAT_W-1:0]           m_axis_tuser     // status[2:0]
);

    t_dp_cmd                     dp_cmd;
    t_dp_stat                    dp_stat;
    logic [KEY_WORDS-1:0][WORD_W-1:0] key_words;
    t_status                     out_status;
    logic [PROV_W-1:0]           out_prov;
    logic [DEF_W-1:0]            out_def;
    logic                        out_fill;

    // unpack the input beat
    assign key_words[0] = s_axis_tdata[67:36];
    assign key_words[1] = s_axis_tdata[99:68];
    assign key_words[2] = s_axis_tdata[131:100];
    assign key_words[3] = s_axis_tdata[163:132];

    // sequencer: idle -> (remainder) -> compare/commit
    hsac_ctrl #(
        .SETS (SETS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    // row store, set index, compare, write-back and output register
    hsac_dp #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .MAX_STROKES (MAX_STROKES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_stat             (dp_stat),
        .i_op               (t_op'(s_axis_tuser)),
        .i_key_hash         (s_axis_tdata[31:0]),
        .i_key_length       (s_axis_tdata[35:32]),
        .i_key_words        (key_words),
        .i_provider         (s_axis_tdata[171:164]),
        .i_definition       (s_axis_tdata[203:172]),
        .i_definition_valid (s_axis_tdata[204]),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_status           (out_status),
        .o_provider         (out_prov),
        .o_definition       (out_def),
        .o_fill             (out_fill)
    );

    // pack the result beat
    assign m_axis_tdata = {7'b0, out_fill, out_def, out_prov};
    assign m_axis_tuser = out_status;

    // ---- checks

    // a committed result is on the master side the following cycle
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.commit |=> m_axis_tvalid)
        else $error("commit without result beat");

    // one item at a time: no second beat right after an accepted one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    // status code stays within the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= STAT_W'(ST_DONE)))
        else $error("undefined status code");

    // fill request only ever accompanies a miss
    a_fill_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[40]) |-> (m_axis_tuser == STAT_W'(ST_MISS)))
        else $error("fill request without miss");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import hsac_pkg::*;

    localparam int SETS         = 64;
    localparam int WAYS         = 4;
    localparam int MAX_STROKES  = 4;
    localparam int ENTRIES      = SETS * WAYS;
    localparam int RANDOM_BEATS = 650;
    localparam int KEY_POOL     = 24;
    localparam int CYCLE_LIMIT  = 400_000;

    // one beat towards the cache
    typedef struct {
        t_op              op;
        logic [31:0]      hash;
        logic [3:0]       len;
        logic [3:0][31:0] words;
        logic [7:0]       prov;
        logic [31:0]      defn;
        logic             defv;
        int               gap;    // idle cycles before the beat is offered
        bit               hold;   // wait for every result before offering it
    } t_beat;

    typedef struct {
        logic [31:0]      hash;
        logic [3:0]       len;
        logic [3:0][31:0] words;
    } t_key;

    typedef struct {
        t_status     status;
        logic [7:0]  prov;
        logic [31:0] defn;
        logic        fill;
    } t_result;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]        s_axis_tuser  = OP_LOOKUP;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;

    hashed_set_assoc_lookup_cache #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .MAX_STROKES (MAX_STROKES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    t_beat   pending_beats[$];
    t_result awaited_results[$];
    int      mismatch_cnt = 0;
    int      cycle_cnt    = 0;

    // shadow copy of the cache contents
    bit               shadow_valid [ENTRIES];
    logic [31:0]      shadow_hash  [ENTRIES];
    logic [2:0]       shadow_len   [ENTRIES];
    logic [3:0][31:0] shadow_words [ENTRIES];
    logic [7:0]       shadow_prov  [ENTRIES];
    bit               shadow_has_def [ENTRIES];
    logic [31:0]      shadow_def   [ENTRIES];
    logic [1:0]       rr_ptr       [SETS];

    initial begin
        for (int e = 0; e < ENTRIES; e++) shadow_valid[e] = 1'b0;
        for (int s = 0; s < SETS; s++) rr_ptr[s] = '0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // lowest valid way whose hash, length and used words agree; -1 on a miss
    function automatic int find_way(input logic [31:0] hash, input logic [3:0] len,
                                    input logic [3:0][31:0] words);
        int  base;
        int  hit = -1;
        bit  same;
        base = int'(hash % SETS) * WAYS;
        for (int w = 0; w < WAYS; w++) begin
            same = shadow_valid[base + w] && shadow_hash[base + w] == hash
                   && {1'b0, shadow_len[base + w]} == len;
            for (int i = 0; i < MAX_STROKES; i++)
                if (i < len && shadow_words[base + w][i] != words[i]) same = 1'b0;
            if (same && hit < 0) hit = base + w;
        end
        return hit;
    endfunction

    // works out the result of one accepted beat and updates the shadow cache
    task automatic cache_predict(input t_beat b);
        t_result r;
        int      e;
        int      set_idx;
        int      slot;
        bit      too_long;
        r        = '{ST_DONE, 8'd0, 32'd0, 1'b0};
        set_idx  = int'(b.hash % SETS);
        too_long = b.len > MAX_STROKES;
        case (b.op)
            OP_LOOKUP: begin
                if (too_long) begin
                    r.status = ST_BYPASS;
                end else begin
                    e = find_way(b.hash, b.len, b.words);
                    if (e < 0) begin
                        r.status = ST_MISS;
                        r.fill   = 1'b1;
                    end else begin
                        r.prov = shadow_prov[e];
                        if (shadow_has_def[e]) begin
                            r.status = ST_HIT_DEF;
                            r.defn   = shadow_def[e];
                        end else begin
                            r.status = ST_HIT_PROV;
                        end
                    end
                end
            end
            OP_INSERT: begin
                // duplicates are not checked for; the pointed way is simply overwritten
                if (!too_long) begin
                    slot = set_idx * WAYS + int'(rr_ptr[set_idx]);
                    rr_ptr[set_idx] = 2'((rr_ptr[set_idx] + 1) % WAYS);
                    shadow_valid[slot] = 1'b1;
                    shadow_hash[slot]  = b.hash;
                    shadow_len[slot]   = b.len[2:0];
                    for (int i = 0; i < MAX_STROKES; i++)
                        shadow_words[slot][i] = (i < b.len) ? b.words[i] : 32'd0;
                    shadow_prov[slot]    = b.prov;
                    shadow_has_def[slot] = b.defv;
                    shadow_def[slot]     = b.defv ? b.defn : 32'd0;
                end
            end
            OP_REFRESH: begin
                if (too_long) begin
                    r.status = ST_BYPASS;
                end else begin
                    e = find_way(b.hash, b.len, b.words);
                    if (e < 0) begin
                        r.status = ST_MISS;
                    end else if (b.defv) begin
                        shadow_has_def[e] = 1'b1;
                        shadow_def[e]     = b.defn;
                    end
                end
            end
            default: begin
                // replace pointers survive a clear
                for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
            end
        endcase
        awaited_results.push_back(r);
    endtask

    // stimulus helpers
    function automatic t_key key_of(input logic [31:0] hash, input logic [3:0] len,
                                    input logic [31:0] fill);
        t_key k;
        k.hash  = hash;
        k.len   = len;
        k.words = {4{fill}};
        return k;
    endfunction

    function automatic t_key fresh_key();
        t_key k;
        k.hash = $urandom;
        // crowd most keys into a few sets so that ways get evicted
        if ($urandom_range(0, 3) != 0) k.hash[5:0] = 6'($urandom_range(0, 7));
        k.len = 4'($urandom_range(0, MAX_STROKES));
        for (int i = 0; i < 4; i++) k.words[i] = $urandom;
        return k;
    endfunction

    task automatic add_beat(input t_op op, input t_key k, input logic [7:0] prov,
                            input logic [31:0] defn, input logic defv, input bit hold);
        t_beat b;
        bit    calm;
        // every fifth stretch of sixty beats goes without sender gaps
        calm    = ((pending_beats.size() / 60) % 5) == 3;
        b.op    = op;
        b.hash  = k.hash;
        b.len   = k.len;
        b.words = k.words;
        // words beyond the length are don't-care, so fill them with noise
        for (int i = 0; i < 4; i++)
            if (i >= k.len) b.words[i] = $urandom;
        b.prov  = prov;
        b.defn  = defn;
        b.defv  = defv;
        b.gap   = calm ? 0 : pick_idle();
        b.hold  = hold;
        pending_beats.push_back(b);
    endtask

    // driver: offers pending beats, feeds accepted ones to the predictor
    t_beat cur_beat;
    int    gap_left = -1;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) cache_predict(cur_beat);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_beats.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    if (gap_left < 0) gap_left = pending_beats[0].gap;
                    if (gap_left > 0) begin
                        gap_left--;
                        s_axis_tvalid <= 1'b0;
                    end else if (pending_beats[0].hold && awaited_results.size() != 0) begin
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        cur_beat = pending_beats.pop_front();
                        gap_left = -1;
                        s_axis_tvalid <= 1'b1;
                        s_axis_tuser  <= cur_beat.op;
                        s_axis_tdata  <= {3'b000, cur_beat.defv, cur_beat.defn, cur_beat.prov,
                                          cur_beat.words, cur_beat.len, cur_beat.hash};
                    end
                end
            end
        end
    end

    // result side back-pressure; one window in four runs without stalls
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (((cycle_cnt / 1500) % 4) != 3) stall_left = pick_idle();
        end
    end

    // monitor
    t_result     want;
    logic [7:0]  got_prov;
    logic [31:0] got_def;
    logic        got_fill;

    task automatic report_mismatch(input string what, input t_result w);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t %s: exp status=%0d prov=%h def=%h fill=%b, %s%0d prov=%h def=%h fill=%b",
                     $time, what, w.status, w.prov, w.defn, w.fill, "got status=",
                     m_axis_tuser, got_prov, got_def, got_fill);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_prov = m_axis_tdata[7:0];
            got_def  = m_axis_tdata[39:8];
            got_fill = m_axis_tdata[40];
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result beat", '{ST_DONE, 8'd0, 32'd0, 1'b0});
            end else begin
                want = awaited_results.pop_front();
                if (m_axis_tuser !== want.status || got_prov !== want.prov
                    || got_def !== want.defn || got_fill !== want.fill)
                    report_mismatch("result mismatch", want);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_key k;
        t_key kx;
        t_key pool [KEY_POOL];
        int   directed_n;
        int   pick;
        int   wi;
        int   bi;
        logic [7:0]  p;
        logic [31:0] d;

        // directed: empty cache, zero length key, extremes of every field
        k = key_of(32'h0000_0000, 4'd0, 32'h0000_0000);
        add_beat(OP_LOOKUP, k, 8'h00, 32'h0, 1'b0, 1'b0);
        add_beat(OP_INSERT, k, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_beat(OP_LOOKUP, k, 8'h00, 32'h0, 1'b0, 1'b0);
        // over-long keys bypass or are ignored
        add_beat(OP_LOOKUP, key_of(32'hFFFF_FFFF, 4'd5, 32'hFFFF_FFFF),
                 8'h00, 32'h0, 1'b0, 1'b0);
        add_beat(OP_LOOKUP, key_of(32'h1234_5678, 4'd15, 32'hA5A5_A5A5),
                 8'h00, 32'h0, 1'b0, 1'b0);
        add_beat(OP_INSERT, key_of(32'h1234_5678, 4'd15, 32'hA5A5_A5A5),
                 8'h11, 32'h1, 1'b1, 1'b0);
        add_beat(OP_REFRESH, key_of(32'h1234_5678, 4'd7, 32'hA5A5_A5A5),
                 8'h00, 32'h2, 1'b1, 1'b0);
        // full length key without a handle, then refreshes with and without one
        k = key_of(32'hFFFF_FFFF, 4'd4, 32'hFFFF_FFFF);
        add_beat(OP_INSERT, k, 8'h00, 32'hDEAD_BEEF, 1'b0, 1'b0);
        add_beat(OP_LOOKUP, k, 8'h00, 32'h0, 1'b0, 1'b0);
        add_beat(OP_REFRESH, k, 8'h00, 32'h5555_AAAA, 1'b0, 1'b0);
        add_beat(OP_LOOKUP, k, 8'h00, 32'h0, 1'b0, 1'b0);
        add_beat(OP_REFRESH, k, 8'h00, 32'h0000_0000, 1'b1, 1'b0);
        add_beat(OP_LOOKUP, k, 8'h00, 32'h0, 1'b0, 1'b0);
        // refresh with no matching entry
        add_beat(OP_REFRESH, key_of(32'hFFFF_FFFF, 4'd3, 32'hFFFF_FFFF),
                 8'h00, 32'h7, 1'b1, 1'b0);
        // duplicate insert, lowest way wins, then eviction of that way
        k = key_of(32'h0000_0A05, 4'd1, 32'h0000_1234);
        add_beat(OP_INSERT, k, 8'h01, 32'h0000_0100, 1'b1, 1'b0);
        add_beat(OP_INSERT, k, 8'h02, 32'h0000_0200, 1'b1, 1'b1);
        add_beat(OP_LOOKUP, k, 8'h00, 32'h0, 1'b0, 1'b0);
        add_beat(OP_INSERT, key_of(32'h0000_0045, 4'd2, 32'h1), 8'h03, 32'h3, 1'b1, 1'b0);
        add_beat(OP_INSERT, key_of(32'h0000_0085, 4'd3, 32'h2), 8'h04, 32'h4, 1'b0, 1'b0);
        add_beat(OP_INSERT, key_of(32'h0000_00C5, 4'd4, 32'h3), 8'h05, 32'h5, 1'b1, 1'b0);
        add_beat(OP_LOOKUP, k, 8'h00, 32'h0, 1'b0, 1'b0);
        // clear drops everything
        add_beat(OP_CLEAR, k, 8'h00, 32'h0, 1'b0, 1'b0);
        add_beat(OP_LOOKUP, k, 8'h00, 32'h0, 1'b0, 1'b0);
        add_beat(OP_LOOKUP, key_of(32'h0000_0000, 4'd0, 32'h0), 8'h00, 32'h0, 1'b0, 1'b0);
        directed_n = pending_beats.size();

        // random: mostly miss/insert/hit sequences over a pool of keys
        for (int i = 0; i < KEY_POOL; i++) pool[i] = fresh_key();
        while (pending_beats.size() < directed_n + RANDOM_BEATS) begin
            if ($urandom_range(0, 99) < 6) begin
                kx = fresh_key();
                // sometimes a sibling: same hash, different length or words
                if ($urandom_range(0, 1) != 0)
                    kx.hash = pool[$urandom_range(0, KEY_POOL - 1)].hash;
                pool[$urandom_range(0, KEY_POOL - 1)] = kx;
            end
            k    = pool[$urandom_range(0, KEY_POOL - 1)];
            pick = $urandom_range(0, 99);
            p    = 8'($urandom_range(0, 255));
            d    = $urandom;
            if (pick < 45) begin
                add_beat(OP_LOOKUP, k, 8'h00, $urandom, 1'($urandom), $urandom_range(0, 99) == 0);
                add_beat(OP_INSERT, k, p, d, 1'($urandom), 1'b0);
                add_beat(OP_LOOKUP, k, 8'($urandom), $urandom, 1'($urandom), 1'b0);
                if ($urandom_range(0, 1) != 0) begin
                    add_beat(OP_REFRESH, k, 8'($urandom), $urandom, 1'($urandom), 1'b0);
                    add_beat(OP_LOOKUP, k, 8'h00, 32'h0, 1'b0, 1'b0);
                end
            end else if (pick < 65) begin
                add_beat(OP_LOOKUP, k, p, d, 1'($urandom), 1'b0);
            end else if (pick < 75) begin
                add_beat(OP_REFRESH, k, p, d, 1'($urandom), 1'b0);
            end else if (pick < 77) begin
                add_beat(OP_CLEAR, k, p, d, 1'($urandom), 1'b0);
            end else if (pick < 87) begin
                // near miss: one bit of hash or a used word flipped, or length off by one
                kx = k;
                case ($urandom_range(0, 2))
                    0: begin
                        bi = $urandom_range(0, 31);
                        kx.hash[bi] = ~kx.hash[bi];
                    end
                    1: kx.len = (k.len == 0) ? 4'd1 : k.len - 4'd1;
                    default: begin
                        if (k.len != 0) begin
                            wi = $urandom_range(0, int'(k.len) - 1);
                            bi = $urandom_range(0, 31);
                            kx.words[wi][bi] = ~kx.words[wi][bi];
                        end
                    end
                endcase
                add_beat(($urandom_range(0, 3) == 0) ? OP_REFRESH : OP_LOOKUP,
                         kx, p, d, 1'($urandom), 1'b0);
            end else begin
                // noise: any op, any length up to 15
                kx.hash = $urandom;
                kx.len  = 4'($urandom_range(0, 15));
                for (int i = 0; i < 4; i++) kx.words[i] = $urandom;
                pick = $urandom_range(0, 3);
                if (pick == 3 && $urandom_range(0, 3) != 0) pick = 0;
                add_beat(t_op'(pick), kx, p, d, 1'($urandom), 1'b0);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all beats accepted, then every result back, then a short tail
        while (pending_beats.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
